[src/framebuffer_ramdac_registers_defines.svh]
// ----------------------------------------------------------------------------
// framebuffer_ramdac_registers_defines.svh
// assertion macros shared by the ramdac register block
// ----------------------------------------------------------------------------
`ifndef FRAMEBUFFER_RAMDAC_REGISTERS_DEFINES_SVH
`define FRAMEBUFFER_RAMDAC_REGISTERS_DEFINES_SVH

// same-cycle implication, clocked on clock, off during reset
`define FBRD_ASSERT_HOLDS(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// next-cycle implication, clocked on clock, off during reset
`define FBRD_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[src/fbrd_pkg.sv]
// ----------------------------------------------------------------------------
// fbrd_pkg
// item types, command codes and palette write port type of the ramdac block
// ----------------------------------------------------------------------------
package fbrd_pkg;

   localparam logic [2:0] CMD_READ_BYTE  = 3'd0;
   localparam logic [2:0] CMD_WRITE_BYTE = 3'd1;
   localparam logic [2:0] CMD_WRITE_LONG = 3'd2;
   localparam logic [2:0] CMD_FRAME_END  = 3'd3;
   localparam logic [2:0] CMD_LOOKUP     = 3'd4;

   localparam int INDEX_VALUES = 256;

   typedef struct packed {
      logic [2:0]  command;
      logic [4:0]  address;
      logic [31:0] write_data;
      logic [7:0]  pixel_index;
   } req_item_type;

   typedef struct packed {
      logic [7:0]  read_data;
      logic [23:0] pixel_color;
      logic        irq_pending;
      logic        redraw_needed;
   } rsp_item_type;

   // lane_en bits: red, green, blue; color packed the same way
   typedef struct packed {
      logic [2:0]  lane_en;
      logic [23:0] color;
   } pal_write_type;

endpackage

[src/fbrd_palette.sv]
// ----------------------------------------------------------------------------
// fbrd_palette
// three color memories with one write and one registered read port,
// cleared by one pass over every entry after reset
// ----------------------------------------------------------------------------
module fbrd_palette #(
   parameter int PALETTE_ENTRIES = 256,
   localparam int ADDR_W = $clog2(PALETTE_ENTRIES)
) (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   wr_en,
   input  logic [ADDR_W-1:0]      wr_addr,
   input  fbrd_pkg::pal_write_type wr_cmd,
   input  logic                   rd_en,
   input  logic [ADDR_W-1:0]      rd_addr,
   output logic [23:0]            rd_color,
   output logic                   clearing
);
   import fbrd_pkg::*;

   localparam logic [ADDR_W-1:0] LAST_SLOT = ADDR_W'(PALETTE_ENTRIES - 1);

   logic [7:0] red_mem_ff   [PALETTE_ENTRIES];
   logic [7:0] green_mem_ff [PALETTE_ENTRIES];
   logic [7:0] blue_mem_ff  [PALETTE_ENTRIES];

   logic              clearing_ff, clearing_in;
   logic [ADDR_W-1:0] clear_addr_ff, clear_addr_in;

   logic [7:0] rd_red_ff;
   logic [7:0] rd_green_ff;
   logic [7:0] rd_blue_ff;

   always_ff @(posedge clock) begin
      if (clearing_ff) begin
         red_mem_ff[clear_addr_ff]   <= 8'h00;
         green_mem_ff[clear_addr_ff] <= 8'h00;
         blue_mem_ff[clear_addr_ff]  <= 8'h00;
      end else begin
         if (wr_en && wr_cmd.lane_en[2]) begin
            red_mem_ff[wr_addr] <= wr_cmd.color[23:16];
         end
         if (wr_en && wr_cmd.lane_en[1]) begin
            green_mem_ff[wr_addr] <= wr_cmd.color[15:8];
         end
         if (wr_en && wr_cmd.lane_en[0]) begin
            blue_mem_ff[wr_addr] <= wr_cmd.color[7:0];
         end
      end
      if (rd_en) begin
         rd_red_ff   <= red_mem_ff[rd_addr];
         rd_green_ff <= green_mem_ff[rd_addr];
         rd_blue_ff  <= blue_mem_ff[rd_addr];
      end
   end

   // clearing pass
   always_comb begin
      clearing_in   = clearing_ff;
      clear_addr_in = clear_addr_ff;
      if (clearing_ff) begin
         clear_addr_in = clear_addr_ff + 1'b1;
         if (clear_addr_ff == LAST_SLOT) begin
            clearing_in = 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         clearing_ff   <= 1'b1;
         clear_addr_ff <= '0;
      end else begin
         clearing_ff   <= clearing_in;
         clear_addr_ff <= clear_addr_in;
      end
   end

   assign clearing = clearing_ff;
   assign rd_color = {rd_red_ff, rd_green_ff, rd_blue_ff};

endmodule

[src/framebuffer_ramdac_registers.sv]
// ----------------------------------------------------------------------------
// framebuffer_ramdac_registers
// Palette ramdac register block: byte reads and writes, long writes to the
// palette data port, frame-end events and pixel lookups, one result per item.
// An item is taken into an input register and its result comes out of an
// output register. One item per cycle is sustained while the output is not
// stalled, except a long write to the palette data port that starts in the
// red, green or blue phase: it touches two palette entries and the palette
// memory has a single write port, so it holds the input register until both
// entries are written. After reset the palette is cleared by one pass over
// its entries, during which req_ready is low.
// ----------------------------------------------------------------------------
`include "framebuffer_ramdac_registers_defines.svh"

module framebuffer_ramdac_registers #(
   parameter int PALETTE_ENTRIES = 256
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  fbrd_pkg::req_item_type req_payload,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output fbrd_pkg::rsp_item_type rsp_payload
);
   import fbrd_pkg::*;

   localparam int ADDR_W      = $clog2(PALETTE_ENTRIES);
   localparam int SPARE_COUNT = 14;

   localparam logic [4:0] ADDR_POINTER     = 5'h00;
   localparam logic [4:0] ADDR_DATA        = 5'h04;
   localparam logic [4:0] ADDR_CONTROL     = 5'h10;
   localparam logic [4:0] ADDR_STATUS      = 5'h11;
   localparam logic [4:0] ADDR_SPARE_FIRST = 5'h12;
   localparam logic [4:0] ADDR_SPARE_LAST  = 5'h1f;

   localparam logic [1:0] PHASE_RED   = 2'd0;
   localparam logic [1:0] PHASE_GREEN = 2'd1;
   localparam logic [1:0] PHASE_BLUE  = 2'd2;
   localparam logic [1:0] PHASE_SKIP  = 2'd3;

   localparam logic [7:0] STATUS_BASE      = 8'h71;
   localparam logic [7:0] STATUS_VSYNC     = 8'h80;
   localparam int         VSYNC_ENABLE_BIT = 7;

   logic [ADDR_W-1:0] slot_table [INDEX_VALUES];

   req_item_type in_ff;
   logic         in_valid_ff, in_valid_in;
   logic         second_ff, second_in;

   logic [7:0] pointer_ff, pointer_in;
   logic [1:0] phase_ff, phase_in;
   logic [7:0] control_ff, control_in;
   logic       vsync_ff, vsync_in;
   logic       redraw_ff, redraw_in;
   logic [7:0] spare_ff [SPARE_COUNT];
   logic [7:0] spare_in [SPARE_COUNT];

   logic       rsp_valid_ff, rsp_valid_in;
   logic [7:0] read_data_ff;
   logic       irq_ff;
   logic       redraw_out_ff;
   logic       lookup_ff;

   logic [2:0]  cmd;
   logic [4:0]  addr;
   logic [31:0] wd;
   logic [7:0]  ptr_next1;
   logic [7:0]  ptr_next2;
   logic [ADDR_W-1:0] p_slot;
   logic [ADDR_W-1:0] q_slot;
   logic [ADDR_W-1:0] pix_slot;
   logic [3:0]  spare_idx;
   logic        spare_hit;
   logic        data_write;
   logic        split_write;
   logic        vsync_arm;
   logic        out_room;
   logic        fire;
   logic [7:0]  read_value;

   logic              pal_wr_en;
   logic [ADDR_W-1:0] pal_wr_addr;
   pal_write_type     pal_wr;
   logic              pal_rd_en;
   logic [23:0]       pal_color;
   logic              pal_clearing;

   for (genvar gi = 0; gi < INDEX_VALUES; gi++) begin : g_slot
      assign slot_table[gi] = ADDR_W'(gi % PALETTE_ENTRIES);
   end

   assign cmd       = in_ff.command;
   assign addr      = in_ff.address;
   assign wd        = in_ff.write_data;
   assign ptr_next1 = pointer_ff + 8'd1;
   assign ptr_next2 = pointer_ff + 8'd2;
   assign p_slot    = slot_table[pointer_ff];
   assign q_slot    = slot_table[ptr_next1];
   assign pix_slot  = slot_table[in_ff.pixel_index];
   assign spare_idx = 4'(addr - ADDR_SPARE_FIRST);
   assign spare_hit = addr inside {[ADDR_SPARE_FIRST:ADDR_SPARE_LAST]};

   assign data_write  = ((cmd == CMD_WRITE_BYTE) || (cmd == CMD_WRITE_LONG)) &&
                        (addr == ADDR_DATA);
   assign split_write = (cmd == CMD_WRITE_LONG) && (addr == ADDR_DATA) &&
                        (phase_ff != PHASE_SKIP);
   assign vsync_arm   = (cmd == CMD_FRAME_END) && control_ff[VSYNC_ENABLE_BIT];

   assign out_room  = !rsp_valid_ff || rsp_ready;
   assign fire      = in_valid_ff && out_room && !(split_write && !second_ff);
   assign req_ready = !pal_clearing && (!in_valid_ff || fire);

   // input stage
   always_comb begin
      in_valid_in = in_valid_ff;
      second_in   = second_ff;
      if (fire) begin
         in_valid_in = 1'b0;
         second_in   = 1'b0;
      end else if (in_valid_ff && split_write) begin
         second_in = 1'b1;
      end
      if (req_valid && req_ready) begin
         in_valid_in = 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (req_valid && req_ready) begin
         in_ff <= req_payload;
      end
   end

   // palette write port
   always_comb begin
      pal_wr_en   = 1'b0;
      pal_wr_addr = p_slot;
      pal_wr      = '{lane_en: 3'b000, color: 24'h0};
      if (in_valid_ff && (cmd == CMD_WRITE_BYTE) && (addr == ADDR_DATA)) begin
         pal_wr_en    = fire;
         pal_wr.color = {3{wd[7:0]}};
         case (phase_ff)
            PHASE_RED:   pal_wr.lane_en = 3'b100;
            PHASE_GREEN: pal_wr.lane_en = 3'b010;
            PHASE_BLUE:  pal_wr.lane_en = 3'b001;
            default:     pal_wr.lane_en = 3'b000;
         endcase
      end else if (in_valid_ff && split_write && second_ff) begin
         pal_wr_en   = fire;
         pal_wr_addr = q_slot;
         case (phase_ff)
            PHASE_RED:   pal_wr = '{lane_en: 3'b100, color: {wd[7:0], 16'h0}};
            PHASE_GREEN: pal_wr = '{lane_en: 3'b110, color: {wd[15:0], 8'h0}};
            default:     pal_wr = '{lane_en: 3'b111, color: wd[23:0]};
         endcase
      end else if (in_valid_ff && split_write) begin
         pal_wr_en = 1'b1;
         case (phase_ff)
            PHASE_RED:   pal_wr = '{lane_en: 3'b111, color: wd[31:8]};
            PHASE_GREEN: pal_wr = '{lane_en: 3'b011, color: {8'h0, wd[31:16]}};
            default:     pal_wr = '{lane_en: 3'b001, color: {16'h0, wd[31:24]}};
         endcase
      end
   end

   assign pal_rd_en = fire && (cmd == CMD_LOOKUP);

   fbrd_palette #(
      .PALETTE_ENTRIES (PALETTE_ENTRIES)
   ) u_palette (
      .clock    (clock),
      .reset    (reset),
      .wr_en    (pal_wr_en),
      .wr_addr  (pal_wr_addr),
      .wr_cmd   (pal_wr),
      .rd_en    (pal_rd_en),
      .rd_addr  (pix_slot),
      .rd_color (pal_color),
      .clearing (pal_clearing)
   );

   // register file reads
   always_comb begin
      read_value = 8'h00;
      if (cmd == CMD_READ_BYTE) begin
         if (addr == ADDR_CONTROL) begin
            read_value = control_ff;
         end else if (addr == ADDR_STATUS) begin
            read_value = STATUS_BASE | (vsync_ff ? STATUS_VSYNC : 8'h00);
         end else if (spare_hit) begin
            read_value = spare_ff[spare_idx];
         end
      end
   end

   // register updates
   always_comb begin
      pointer_in = pointer_ff;
      phase_in   = phase_ff;
      control_in = control_ff;
      vsync_in   = vsync_ff;
      redraw_in  = redraw_ff;
      spare_in   = spare_ff;
      if (fire) begin
         case (cmd)
            CMD_WRITE_BYTE: begin
               if (addr == ADDR_POINTER) begin
                  pointer_in = wd[7:0];
                  phase_in   = PHASE_RED;
               end else if (addr == ADDR_DATA) begin
                  redraw_in = 1'b1;
                  case (phase_ff)
                     PHASE_RED:   phase_in = PHASE_GREEN;
                     PHASE_GREEN: phase_in = PHASE_BLUE;
                     PHASE_BLUE: begin
                        phase_in   = PHASE_RED;
                        pointer_in = ptr_next1;
                     end
                     default:     phase_in = PHASE_RED;
                  endcase
               end else if (addr == ADDR_CONTROL) begin
                  control_in = wd[7:0];
               end else if (addr == ADDR_STATUS) begin
                  vsync_in = 1'b0;
               end else if (spare_hit) begin
                  spare_in[spare_idx] = wd[7:0];
               end
            end
            CMD_WRITE_LONG: begin
               if (addr == ADDR_POINTER) begin
                  pointer_in = wd[7:0];
                  phase_in   = PHASE_RED;
               end else if (addr == ADDR_DATA) begin
                  redraw_in  = 1'b1;
                  pointer_in = ptr_next1;
                  case (phase_ff)
                     PHASE_RED:   phase_in = PHASE_GREEN;
                     PHASE_GREEN: phase_in = PHASE_BLUE;
                     PHASE_BLUE: begin
                        phase_in   = PHASE_RED;
                        pointer_in = ptr_next2;
                     end
                     default:     phase_in = PHASE_RED;
                  endcase
               end
            end
            CMD_FRAME_END: begin
               if (control_ff[VSYNC_ENABLE_BIT]) begin
                  vsync_in = 1'b1;
               end
               redraw_in = 1'b0;
            end
            default: begin
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         second_ff   <= 1'b0;
         pointer_ff  <= 8'h00;
         phase_ff    <= PHASE_RED;
         control_ff  <= 8'h00;
         vsync_ff    <= 1'b0;
         redraw_ff   <= 1'b1;
         spare_ff    <= '{default: 8'h00};
      end else begin
         in_valid_ff <= in_valid_in;
         second_ff   <= second_in;
         pointer_ff  <= pointer_in;
         phase_ff    <= phase_in;
         control_ff  <= control_in;
         vsync_ff    <= vsync_in;
         redraw_ff   <= redraw_in;
         spare_ff    <= spare_in;
      end
   end

   // output stage
   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (fire) begin
         rsp_valid_in = 1'b1;
      end else if (rsp_ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (fire) begin
         read_data_ff  <= read_value;
         irq_ff        <= vsync_in;
         redraw_out_ff <= redraw_in;
         lookup_ff     <= (cmd == CMD_LOOKUP);
      end
   end

   assign rsp_valid   = rsp_valid_ff;
   assign rsp_payload = '{read_data:     read_data_ff,
                          pixel_color:   lookup_ff ? pal_color : 24'h0,
                          irq_pending:   irq_ff,
                          redraw_needed: redraw_out_ff};

   `FBRD_ASSERT_HOLDS(a_second_half_owner, second_ff, in_valid_ff && split_write, "stray half")
   `FBRD_ASSERT_NEXT(a_data_write_redraw, fire && data_write, redraw_ff, "redraw not set")
   `FBRD_ASSERT_NEXT(a_frame_end_vsync, fire && vsync_arm, vsync_ff, "vsync not raised")

endmodule

[dv/framebuffer_ramdac_registers_test.sv]
// ----------------------------------------------------------------------------
// framebuffer_ramdac_registers_test
// Self-checking bench for the ramdac register block. A shadow copy of the
// palette, pointer, phase, control, spare and flag state predicts every
// result. Directed items cover register reads and writes, long writes in
// each phase, pointer wrap and frame ends. Random palette bursts, vsync
// sequences and noise items then run under changing sender and receiver
// idling. Results are compared field by field in order.
// ----------------------------------------------------------------------------
module framebuffer_ramdac_registers_test;
   import fbrd_pkg::*;

   localparam int PALETTE_ENTRIES = 256;
   localparam logic [4:0] ADDR_POINTER = 5'h00;
   localparam logic [4:0] ADDR_UNMAPPED = 5'h03;
   localparam logic [4:0] ADDR_DATA = 5'h04;
   localparam logic [4:0] ADDR_CONTROL = 5'h10;
   localparam logic [4:0] ADDR_STATUS = 5'h11;
   localparam logic [4:0] ADDR_SPARE_FIRST = 5'h12;
   localparam logic [4:0] ADDR_SPARE_LAST = 5'h1f;
   localparam logic [7:0] STATUS_FIXED_BITS = 8'h71;
   localparam int VSYNC_ENABLE_BIT = 7;
   localparam logic [2:0] CMD_UNUSED_LOW = 3'd5;
   localparam logic [2:0] CMD_UNUSED_HIGH = 3'd7;
   localparam int WATCHDOG_LIMIT = 4000;
   localparam int DRAIN_CYCLES = 16;
   localparam int PHASE_ITEMS = 380;

   typedef enum logic [1:0] {
      PHASE_RED,
      PHASE_GREEN,
      PHASE_BLUE,
      PHASE_SKIP
   } color_phase_type;

   class ramdac_mirror;
      logic [7:0] red [PALETTE_ENTRIES];
      logic [7:0] green [PALETTE_ENTRIES];
      logic [7:0] blue [PALETTE_ENTRIES];
      logic [7:0] spare [14];
      logic [7:0] pointer;
      logic [7:0] control;
      color_phase_type phase;
      logic vsync;
      logic redraw;
      rsp_item_type expected_results [$];
      bit failed;
      int mismatches;

      function new();
         foreach (red[i]) begin
            red[i] = '0;
            green[i] = '0;
            blue[i] = '0;
         end
         foreach (spare[i]) spare[i] = '0;
         pointer = '0;
         control = '0;
         phase = PHASE_RED;
         vsync = 1'b0;
         redraw = 1'b1;
         failed = 1'b0;
         mismatches = 0;
      endfunction

      function void note_request(req_item_type r);
         rsp_item_type e;
         logic [7:0] v;
         logic [7:0] nxt;
         logic [31:0] wd;
         int p;
         int q;
         e = '0;
         wd = r.write_data;
         v = wd[7:0];
         p = pointer % PALETTE_ENTRIES;
         case (r.command)
            CMD_READ_BYTE: begin
               if (r.address == ADDR_CONTROL) e.read_data = control;
               else if (r.address == ADDR_STATUS)
                  e.read_data = STATUS_FIXED_BITS | {vsync, 7'd0};
               else if (r.address >= ADDR_SPARE_FIRST)
                  e.read_data = spare[r.address - ADDR_SPARE_FIRST];
            end
            CMD_WRITE_BYTE: begin
               if (r.address == ADDR_POINTER) begin
                  pointer = v;
                  phase = PHASE_RED;
               end else if (r.address == ADDR_DATA) begin
                  case (phase)
                     PHASE_RED: begin
                        red[p] = v;
                        phase = PHASE_GREEN;
                     end
                     PHASE_GREEN: begin
                        green[p] = v;
                        phase = PHASE_BLUE;
                     end
                     PHASE_BLUE: begin
                        blue[p] = v;
                        pointer = pointer + 8'd1;
                        phase = PHASE_RED;
                     end
                     default: phase = PHASE_RED;
                  endcase
                  redraw = 1'b1;
               end else if (r.address == ADDR_CONTROL) begin
                  control = v;
               end else if (r.address == ADDR_STATUS) begin
                  vsync = 1'b0;
               end else if (r.address >= ADDR_SPARE_FIRST) begin
                  spare[r.address - ADDR_SPARE_FIRST] = v;
               end
            end
            CMD_WRITE_LONG: begin
               if (r.address == ADDR_POINTER) begin
                  pointer = v;
                  phase = PHASE_RED;
               end else if (r.address == ADDR_DATA) begin
                  nxt = pointer + 8'd1;
                  q = nxt % PALETTE_ENTRIES;
                  case (phase)
                     PHASE_RED: begin
                        red[p] = wd[31:24];
                        green[p] = wd[23:16];
                        blue[p] = wd[15:8];
                        red[q] = wd[7:0];
                        phase = PHASE_GREEN;
                     end
                     PHASE_GREEN: begin
                        green[p] = wd[31:24];
                        blue[p] = wd[23:16];
                        red[q] = wd[15:8];
                        green[q] = wd[7:0];
                        phase = PHASE_BLUE;
                     end
                     PHASE_BLUE: begin
                        blue[p] = wd[31:24];
                        red[q] = wd[23:16];
                        green[q] = wd[15:8];
                        blue[q] = wd[7:0];
                        nxt = nxt + 8'd1;
                        phase = PHASE_RED;
                     end
                     default: phase = PHASE_RED;
                  endcase
                  pointer = nxt;
                  redraw = 1'b1;
               end
            end
            CMD_FRAME_END: begin
               if (control[VSYNC_ENABLE_BIT]) vsync = 1'b1;
               redraw = 1'b0;
            end
            CMD_LOOKUP: begin
               p = r.pixel_index % PALETTE_ENTRIES;
               e.pixel_color = {red[p], green[p], blue[p]};
            end
            default: ;
         endcase
         e.irq_pending = vsync;
         e.redraw_needed = redraw;
         expected_results.push_back(e);
      endfunction

      function void report(string what, logic [63:0] want, logic [63:0] got);
         failed = 1'b1;
         mismatches++;
         $display("%0t: %s expected %h actual %h", $time, what, want, got);
      endfunction

      function void check_result(rsp_item_type got);
         rsp_item_type want;
         if (expected_results.size() == 0) begin
            report("result with nothing pending", '0, got);
            return;
         end
         want = expected_results.pop_front();
         if (got.read_data !== want.read_data)
            report("read_data", want.read_data, got.read_data);
         if (got.pixel_color !== want.pixel_color)
            report("pixel_color", want.pixel_color, got.pixel_color);
         if (got.irq_pending !== want.irq_pending)
            report("irq_pending", want.irq_pending, got.irq_pending);
         if (got.redraw_needed !== want.redraw_needed)
            report("redraw_needed", want.redraw_needed, got.redraw_needed);
      endfunction
   endclass

   logic clock;
   logic reset;
   logic req_valid;
   logic req_ready;
   req_item_type req_payload;
   logic rsp_valid;
   logic rsp_ready;
   rsp_item_type rsp_payload;

   int idle_pct;
   int stall_pct;
   int items_sent;
   int idle_cycles;
   ramdac_mirror mirror = new();

   framebuffer_ramdac_registers #(
      .PALETTE_ENTRIES(PALETTE_ENTRIES)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_valid(req_valid),
      .req_ready(req_ready),
      .req_payload(req_payload),
      .rsp_valid(rsp_valid),
      .rsp_ready(rsp_ready),
      .rsp_payload(rsp_payload)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   always @(negedge clock) begin
      rsp_ready <= ($urandom_range(99) >= stall_pct);
   end

   always @(posedge clock) begin
      if (reset) begin
         idle_cycles <= 0;
      end else begin
         if (req_valid && req_ready) mirror.note_request(req_payload);
         if (rsp_valid && rsp_ready) mirror.check_result(rsp_payload);
         if ((req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
            idle_cycles <= 0;
         end else if (idle_cycles >= WATCHDOG_LIMIT) begin
            $display("simulation failed");
            $finish;
         end else begin
            idle_cycles <= idle_cycles + 1;
         end
      end
   end

   task automatic send_item(input req_item_type item);
      @(negedge clock);
      while ($urandom_range(99) < idle_pct) begin
         req_valid <= 1'b0;
         @(negedge clock);
      end
      req_valid <= 1'b1;
      req_payload <= item;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      items_sent++;
   endtask

   task automatic send_fields(input logic [2:0] cmd, input logic [4:0] addr,
                              input logic [31:0] data, input logic [7:0] pix);
      req_item_type it;
      it.command = cmd;
      it.address = addr;
      it.write_data = data;
      it.pixel_index = pix;
      send_item(it);
   endtask

   function automatic req_item_type random_request();
      req_item_type it;
      int pick;
      it.write_data = $urandom;
      it.pixel_index = 8'($urandom_range(255));
      pick = $urandom_range(99);
      if (pick < 55) it.address = ADDR_DATA;
      else if (pick < 65) it.address = ADDR_POINTER;
      else if (pick < 85) it.address = 5'($urandom_range(ADDR_CONTROL, ADDR_SPARE_LAST));
      else it.address = 5'($urandom_range(31));
      pick = $urandom_range(99);
      if (pick < 15) it.command = CMD_READ_BYTE;
      else if (pick < 40) it.command = CMD_WRITE_BYTE;
      else if (pick < 55) it.command = CMD_WRITE_LONG;
      else if (pick < 62) it.command = CMD_FRAME_END;
      else if (pick < 95) it.command = CMD_LOOKUP;
      else it.command = 3'($urandom_range(CMD_UNUSED_LOW, CMD_UNUSED_HIGH));
      return it;
   endfunction

   // set the pointer, stream color bytes, then look the entries back up
   task automatic palette_burst();
      req_item_type it;
      logic [7:0] base;
      int writes;
      int looks;
      it = random_request();
      it.command = $urandom_range(1) ? CMD_WRITE_BYTE : CMD_WRITE_LONG;
      it.address = ADDR_POINTER;
      if ($urandom_range(3) == 0) it.write_data[7:0] = 8'hfc + 8'($urandom_range(3));
      base = it.write_data[7:0];
      send_item(it);
      writes = $urandom_range(1, 12);
      repeat (writes) begin
         it = random_request();
         if ($urandom_range(9) != 0) begin
            it.command = $urandom_range(1) ? CMD_WRITE_BYTE : CMD_WRITE_LONG;
            it.address = ADDR_DATA;
         end
         send_item(it);
      end
      looks = $urandom_range(1, 6);
      for (int i = 0; i < looks; i++) begin
         it = random_request();
         it.command = CMD_LOOKUP;
         it.pixel_index = base + 8'(i);
         send_item(it);
      end
   endtask

   task automatic vsync_sequence();
      logic [31:0] data;
      data = $urandom;
      data[VSYNC_ENABLE_BIT] = ($urandom_range(3) != 0);
      send_fields(CMD_WRITE_BYTE, ADDR_CONTROL, data, 8'($urandom_range(255)));
      send_fields(CMD_FRAME_END, 5'($urandom_range(31)), $urandom,
                  8'($urandom_range(255)));
      send_fields(CMD_READ_BYTE, ADDR_STATUS, $urandom, 8'($urandom_range(255)));
      if ($urandom_range(1)) send_fields(CMD_WRITE_BYTE, ADDR_STATUS, $urandom, 8'h00);
      send_fields(CMD_READ_BYTE, ADDR_STATUS, $urandom, 8'($urandom_range(255)));
   endtask

   task automatic run_phase(input int idle, input int stall, input int count);
      int stop;
      int pick;
      idle_pct = idle;
      stall_pct = stall;
      stop = items_sent + count;
      while (items_sent < stop) begin
         pick = $urandom_range(9);
         if (pick < 5) palette_burst();
         else if (pick < 6) vsync_sequence();
         else send_item(random_request());
      end
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_payload = '0;
      idle_pct = 0;
      stall_pct = 0;
      items_sent = 0;
      repeat (2) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;

      // register reads straight after reset
      send_fields(CMD_READ_BYTE, ADDR_STATUS, 32'h0000_0000, 8'h00);
      send_fields(CMD_READ_BYTE, ADDR_CONTROL, 32'hffff_ffff, 8'hff);
      send_fields(CMD_READ_BYTE, ADDR_SPARE_LAST, 32'h0000_0000, 8'h00);
      send_fields(CMD_READ_BYTE, ADDR_UNMAPPED, 32'hffff_ffff, 8'hff);
      // vsync raise and clear, then a spare register write and read back
      send_fields(CMD_WRITE_BYTE, ADDR_CONTROL, 32'hffff_ff80, 8'h00);
      send_fields(CMD_FRAME_END, ADDR_POINTER, 32'h0000_0000, 8'h00);
      send_fields(CMD_READ_BYTE, ADDR_STATUS, 32'h0000_0000, 8'h00);
      send_fields(CMD_WRITE_BYTE, ADDR_STATUS, 32'h0000_00ff, 8'h00);
      send_fields(CMD_WRITE_BYTE, ADDR_SPARE_FIRST, 32'h5a5a_a5a5, 8'h00);
      send_fields(CMD_READ_BYTE, ADDR_SPARE_FIRST, 32'h0000_0000, 8'h00);
      // byte stream across the pointer wrap
      send_fields(CMD_WRITE_BYTE, ADDR_POINTER, 32'hffff_ffff, 8'h00);
      send_fields(CMD_WRITE_BYTE, ADDR_DATA, 32'h0000_0011, 8'h00);
      send_fields(CMD_WRITE_BYTE, ADDR_DATA, 32'h0000_0022, 8'h00);
      send_fields(CMD_WRITE_BYTE, ADDR_DATA, 32'h0000_0033, 8'h00);
      send_fields(CMD_LOOKUP, ADDR_POINTER, 32'h0000_0000, 8'hff);
      // long writes in every phase, running into the next entry
      send_fields(CMD_WRITE_LONG, ADDR_POINTER, 32'h1234_56fe, 8'h00);
      send_fields(CMD_WRITE_LONG, ADDR_DATA, 32'haabb_ccdd, 8'h00);
      send_fields(CMD_WRITE_LONG, ADDR_DATA, 32'h0102_0304, 8'h00);
      send_fields(CMD_WRITE_LONG, ADDR_DATA, 32'hffee_ddcc, 8'h00);
      send_fields(CMD_LOOKUP, ADDR_POINTER, 32'h0000_0000, 8'hfe);
      send_fields(CMD_LOOKUP, ADDR_POINTER, 32'h0000_0000, 8'h00);
      // long write to a plain register is dropped
      send_fields(CMD_WRITE_LONG, ADDR_CONTROL, 32'hffff_ff00, 8'h00);
      send_fields(CMD_READ_BYTE, ADDR_CONTROL, 32'h0000_0000, 8'h00);
      send_fields(CMD_UNUSED_LOW, ADDR_STATUS, 32'hffff_ffff, 8'hff);
      send_fields(CMD_UNUSED_HIGH, ADDR_DATA, 32'hffff_ffff, 8'hff);
      // pointer write mid-entry restarts at red
      send_fields(CMD_WRITE_BYTE, ADDR_DATA, 32'h0000_0077, 8'h00);
      send_fields(CMD_WRITE_BYTE, ADDR_POINTER, 32'h0000_0040, 8'h00);

      run_phase(0, 0, PHASE_ITEMS);
      run_phase(85, 0, PHASE_ITEMS);
      run_phase(0, 85, PHASE_ITEMS);
      run_phase(33, 33, PHASE_ITEMS);

      @(negedge clock);
      req_valid <= 1'b0;
      while (mirror.expected_results.size() != 0) @(posedge clock);
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (!mirror.failed) begin
         $display("simulation ok");
      end else begin
         $display("simulation failed");
      end
      $finish;
   end
endmodule

[sim.f]
+incdir+src
src/fbrd_pkg.sv
src/fbrd_palette.sv
src/framebuffer_ramdac_registers.sv
dv/framebuffer_ramdac_registers_test.sv
